// ===== sv/pspbc_pkg.sv =====
// Package for the packed sparse polynomial multiply with bound check.
// Holds item codes, register indexes, sequencer states and fixed field widths.
// No dependencies.
package pspbc_pkg;

   localparam int INDEX_W = 10;
   localparam int COEF_W  = 24;
   localparam int RES_W   = 25;
   localparam int BOUND_W = 24;
   localparam int DATA_W  = 64;
   localparam int PADDR_W = 6;
   localparam int LANES   = 4;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_CHAL  = 2'd1,
      FUNC_EMIT  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_ETA      = 3'd0,
      CSR_NEGATE   = 3'd1,
      CSR_OFFSET   = 3'd2,
      CSR_BOUND_Z  = 3'd3,
      CSR_BOUND_W  = 3'd4
   } csr_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_MAC   = 2'd2,
      ST_EMIT  = 2'd3
   } state_type;

endpackage

// ===== sv/packed_sparse_polymul_bound_check_unit.sv =====
// Top level of the packed sparse ternary negacyclic polynomial multiply.
// Secret and accumulator stores are on-chip synchronous memories; uses pspbc_pkg.
//
//  channel  | ports                                   | direction
//  req      | req_valid/req_ready, func,index,c,a,b   | in
//  rsp      | rsp_valid/rsp_ready, index,z,wp,rejected| out
//  csr      | psel,penable,pwrite,paddr,pwdata,prdata | APB slave
//
// Load and ignored items are taken in the idle state. An emit item reads
// its accumulator word in the emit state and waits there while the output
// stalls. A challenge item sweeps all POLY_LENGTH accumulator words, one per
// cycle, through the accumulator read-modify-write port; the next item is
// taken after its last write-back. Clear items and reset both zero all words.
// The result register lets the next item in while a result waits.
module packed_sparse_polymul_bound_check_unit
   import pspbc_pkg::*;
#(
   parameter int POLY_LENGTH = 1024,
   parameter int SLOTS       = 4,
   parameter int SLOT_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [INDEX_W-1:0]         req_index,
   input  logic signed [1:0]          req_coeff_c,
   input  logic signed [COEF_W-1:0]   req_a0,
   input  logic signed [COEF_W-1:0]   req_a1,
   input  logic signed [COEF_W-1:0]   req_a2,
   input  logic signed [COEF_W-1:0]   req_a3,
   input  logic signed [COEF_W-1:0]   req_b0,
   input  logic signed [COEF_W-1:0]   req_b1,
   input  logic signed [COEF_W-1:0]   req_b2,
   input  logic signed [COEF_W-1:0]   req_b3,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_out_index,
   output logic signed [RES_W-1:0]    rsp_z0,
   output logic signed [RES_W-1:0]    rsp_z1,
   output logic signed [RES_W-1:0]    rsp_z2,
   output logic signed [RES_W-1:0]    rsp_z3,
   output logic signed [RES_W-1:0]    rsp_wp0,
   output logic signed [RES_W-1:0]    rsp_wp1,
   output logic signed [RES_W-1:0]    rsp_wp2,
   output logic signed [RES_W-1:0]    rsp_wp3,
   output logic                       rsp_rejected,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]          pwdata,
   output logic [DATA_W-1:0]          prdata,
   output logic                       pready
);

   localparam int AW = $clog2(POLY_LENGTH);
   localparam int WW = SLOTS * SLOT_BITS;
   localparam logic [AW-1:0] LAST = AW'(POLY_LENGTH - 1);
   localparam logic [AW:0]   N_EXT = (AW + 1)'(POLY_LENGTH);

   // configuration
   logic [7:0]         eta_ff;
   logic [DATA_W-1:0]  negw_ff;
   logic [15:0]        off_ff;
   logic [BOUND_W-1:0] bz_ff, bw_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff  <= 8'd2;
         negw_ff <= '0;
         off_ff  <= '0;
         bz_ff   <= '0;
         bw_ff   <= '0;
      end else if (csr_wr) begin
         case (paddr[5:3])
            CSR_ETA:     eta_ff  <= pwdata[7:0];
            CSR_NEGATE:  negw_ff <= pwdata;
            CSR_OFFSET:  off_ff  <= pwdata[15:0];
            CSR_BOUND_Z: bz_ff   <= pwdata[BOUND_W-1:0];
            CSR_BOUND_W: bw_ff   <= pwdata[BOUND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[5:3])
         CSR_ETA:     prdata = DATA_W'(eta_ff);
         CSR_NEGATE:  prdata = negw_ff;
         CSR_OFFSET:  prdata = DATA_W'(off_ff);
         CSR_BOUND_Z: prdata = DATA_W'(bz_ff);
         CSR_BOUND_W: prdata = DATA_W'(bw_ff);
         default:     prdata = '0;
      endcase
   end

   // request decode
   logic signed [COEF_W-1:0] req_a [LANES];
   logic signed [COEF_W-1:0] req_b [LANES];
   logic in_range, req_xfer;

   assign req_a[0] = req_a0;
   assign req_a[1] = req_a1;
   assign req_a[2] = req_a2;
   assign req_a[3] = req_a3;
   assign req_b[0] = req_b0;
   assign req_b[1] = req_b1;
   assign req_b[2] = req_b2;
   assign req_b[3] = req_b3;
   assign in_range = 32'(req_index) < POLY_LENGTH;
   assign req_xfer = req_valid && req_ready;

   // sequencer
   state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          neg_ff, neg_in;
   logic [INDEX_W-1:0] eidx_ff, eidx_in;
   logic signed [COEF_W-1:0] y_ff [LANES];
   logic signed [COEF_W-1:0] w_ff [LANES];
   logic wr_valid_ff, wr_valid_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic wr_neg_ff, wr_neg_in;
   logic out_free, out_load;

   assign out_free = !rsp_valid || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (cnt_ff == LAST) state_in = ST_IDLE;
         ST_MAC:   if (cnt_ff == LAST) state_in = ST_IDLE;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_func)
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_CHAL:  if (in_range && req_coeff_c[0]) state_in = ST_MAC;
                  FUNC_EMIT:  if (in_range) state_in = ST_EMIT;
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic              sec_we;
   logic [WW-1:0]     sec1_wd, sec2_wd;
   logic [AW-1:0]     acc_ra, sec_ra, acc_wa;
   logic              acc_we;
   logic [WW-1:0]     acc1_wd, acc2_wd;
   logic [AW:0]       src_ext;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) && !wr_valid_ff;
      sec_we      = req_xfer && (req_func == FUNC_LOAD) && in_range;
      cnt_in      = (state_ff == ST_IDLE) ? '0 : cnt_ff + 1'b1;
      idx_in      = idx_ff;
      neg_in      = neg_ff;
      eidx_in     = eidx_ff;
      if (req_xfer) begin
         idx_in  = AW'(req_index);
         neg_in  = req_coeff_c[1];
         eidx_in = req_index;
      end
      wr_valid_in = (state_ff == ST_MAC);
      wr_addr_in  = cnt_ff;
      wr_neg_in   = (cnt_ff < idx_ff) ^ neg_ff;
      src_ext     = (cnt_ff < idx_ff) ? ({1'b0, cnt_ff} + N_EXT - {1'b0, idx_ff})
                                      : ({1'b0, cnt_ff} - {1'b0, idx_ff});
      sec_ra      = src_ext[AW-1:0];
      case (state_ff)
         ST_MAC:  acc_ra = cnt_ff;
         ST_EMIT: acc_ra = idx_ff;
         default: acc_ra = AW'(req_index);
      endcase
      out_load    = (state_ff == ST_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         wr_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      neg_ff     <= neg_in;
      eidx_ff    <= eidx_in;
      wr_addr_ff <= wr_addr_in;
      wr_neg_ff  <= wr_neg_in;
      if (req_xfer) begin
         for (int p = 0; p < LANES; p++) begin
            y_ff[p] <= req_a[p];
            w_ff[p] <= req_b[p];
         end
      end
   end

   // secret packing
   always_comb begin
      sec1_wd = '0;
      sec2_wd = '0;
      for (int p = 0; p < SLOTS; p++) begin
         sec1_wd[(SLOTS-1-p)*SLOT_BITS +: SLOT_BITS] =
            req_a[p][SLOT_BITS-1:0] + SLOT_BITS'(eta_ff);
         sec2_wd[(SLOTS-1-p)*SLOT_BITS +: SLOT_BITS] =
            req_b[p][SLOT_BITS-1:0] + SLOT_BITS'(eta_ff);
      end
   end

   // memories: both vectors share one word per index
   logic [2*WW-1:0] sec_mem [POLY_LENGTH];
   logic [2*WW-1:0] acc_mem [POLY_LENGTH];
   logic [2*WW-1:0] sec_rd_ff, acc_rd_ff;
   logic [WW-1:0]   sec1_rd, sec2_rd, acc1_rd, acc2_rd;

   assign {sec1_rd, sec2_rd} = sec_rd_ff;
   assign {acc1_rd, acc2_rd} = acc_rd_ff;

   always_ff @(posedge clock) begin
      if (sec_we) begin
         sec_mem[AW'(req_index)] <= {sec1_wd, sec2_wd};
      end
      sec_rd_ff <= sec_mem[sec_ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= {acc1_wd, acc2_wd};
      end
      acc_rd_ff <= acc_mem[acc_ra];
   end

   // accumulate write-back
   logic [WW-1:0] negw, t1, t2;

   always_comb begin
      negw    = negw_ff[WW-1:0];
      t1      = wr_neg_ff ? negw - sec1_rd : sec1_rd;
      t2      = wr_neg_ff ? negw - sec2_rd : sec2_rd;
      acc_we  = (state_ff == ST_CLEAR) || wr_valid_ff;
      acc_wa  = (state_ff == ST_CLEAR) ? cnt_ff : wr_addr_ff;
      acc1_wd = (state_ff == ST_CLEAR) ? '0 : acc1_rd + t1;
      acc2_wd = (state_ff == ST_CLEAR) ? '0 : acc2_rd + t2;
   end

   // emit datapath
   logic signed [RES_W-1:0] z_in [LANES];
   logic signed [RES_W-1:0] wp_in [LANES];
   logic hit;

   always_comb begin
      hit = 1'b0;
      for (int p = 0; p < LANES; p++) begin
         z_in[p]  = '0;
         wp_in[p] = '0;
      end
      for (int p = 0; p < SLOTS; p++) begin
         logic [SLOT_BITS-1:0] s1, s2;
         logic signed [RES_W:0] u1, u2, z, wp, bz, bw;
         s1 = SLOT_BITS'(acc1_rd >> ((SLOTS - 1 - p) * SLOT_BITS));
         s2 = SLOT_BITS'(acc2_rd >> ((SLOTS - 1 - p) * SLOT_BITS));
         u1 = $signed((RES_W + 1)'(s1)) - $signed((RES_W + 1)'(off_ff));
         u2 = $signed((RES_W + 1)'(s2)) - $signed((RES_W + 1)'(off_ff));
         z  = u1 + (RES_W + 1)'(y_ff[p]);
         wp = (RES_W + 1)'(w_ff[p]) - u2;
         bz = $signed((RES_W + 1)'(bz_ff));
         bw = $signed((RES_W + 1)'(bw_ff));
         if (z >= bz || z <= -bz || wp >= bw || wp <= -bw) hit = 1'b1;
         z_in[p]  = z[RES_W-1:0];
         wp_in[p] = wp[RES_W-1:0];
      end
   end

   // result register
   logic reject_ff;
   logic signed [RES_W-1:0] z_ff [LANES];
   logic signed [RES_W-1:0] wp_ff [LANES];
   logic [INDEX_W-1:0] out_idx_ff;
   logic rsp_valid_ff, rsp_rej_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reject_ff    <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            reject_ff    <= reject_ff | hit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_idx_ff <= eidx_ff;
         rsp_rej_ff <= reject_ff | hit;
         for (int p = 0; p < LANES; p++) begin
            z_ff[p]  <= z_in[p];
            wp_ff[p] <= wp_in[p];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = out_idx_ff;
   assign rsp_rejected  = rsp_rej_ff;
   assign rsp_z0  = z_ff[0];
   assign rsp_z1  = z_ff[1];
   assign rsp_z2  = z_ff[2];
   assign rsp_z3  = z_ff[3];
   assign rsp_wp0 = wp_ff[0];
   assign rsp_wp1 = wp_ff[1];
   assign rsp_wp2 = wp_ff[2];
   assign rsp_wp3 = wp_ff[3];

   // checks
   a_no_clear_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_valid_ff && state_ff == ST_CLEAR))
      else $error("accumulate write-back overlaps clearing pass");

   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(reject_ff) |-> reject_ff)
      else $error("reject flag dropped");

   a_emit_not_during_writeback: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> !req_ready)
      else $error("item taken while accumulator write pending");

endmodule

// ===== dv/tb_packed_sparse_polymul_bound_check_unit.sv =====
// Self-checking testbench for packed_sparse_polymul_bound_check_unit.
// Drives loads, challenge terms, emits and clears through a valid/ready
// driver, predicts each emit result, and checks it at the monitor; uses pspbc_pkg.
module tb_packed_sparse_polymul_bound_check_unit
   import pspbc_pkg::*;
();

   localparam int NPOS     = 1024;
   localparam int SETTLE   = 1100;
   localparam int WD_LIMIT = 20000;

   typedef struct {
      func_type          func;
      logic [9:0]        idx;
      logic signed [1:0] c;
      logic [3:0][23:0]  a;
      logic [3:0][23:0]  b;
   } req_item_type;

   typedef struct {
      logic [9:0]       idx;
      logic [3:0][24:0] z;
      logic [3:0][24:0] wp;
      logic             rej;
   } emit_result_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_func;
   logic [INDEX_W-1:0] req_index;
   logic signed [1:0] req_coeff_c;
   logic signed [COEF_W-1:0] req_a0, req_a1, req_a2, req_a3;
   logic signed [COEF_W-1:0] req_b0, req_b1, req_b2, req_b3;
   logic rsp_valid, rsp_ready;
   logic [INDEX_W-1:0] rsp_out_index;
   logic signed [RES_W-1:0] rsp_z0, rsp_z1, rsp_z2, rsp_z3;
   logic signed [RES_W-1:0] rsp_wp0, rsp_wp1, rsp_wp2, rsp_wp3;
   logic rsp_rejected;
   logic psel, penable, pwrite, pready;
   logic [PADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   packed_sparse_polymul_bound_check_unit i_dut (.*);

   // predictor state
   logic [63:0] s1_mem [NPOS];
   logic [63:0] s2_mem [NPOS];
   logic [63:0] acc1_mem [NPOS];
   logic [63:0] acc2_mem [NPOS];
   logic        reject_seen;
   logic [7:0]  cfg_eta;
   logic [63:0] cfg_negate;
   logic [15:0] cfg_offset;
   logic [23:0] cfg_bound_z, cfg_bound_w;

   req_item_type    pending_q [$];
   emit_result_type emit_q [$];
   req_item_type    cur_item;
   int              err_count;
   bit              quiet;
   logic            req_fire;
   int              req_gap, rsp_gap, idle_cycles;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      err_count++;
   endtask

   function automatic logic [63:0] pack_secret(input logic [3:0][23:0] v);
      logic [63:0] w;
      logic [63:0] slot;
      w = 0;
      for (int p = 0; p < 4; p++) begin
         slot = (64'(cfg_eta) + 64'(longint'(signed'(v[p])))) & 64'hFFFF;
         w |= slot << ((3 - p) * 16);
      end
      return w;
   endfunction

   function automatic bit beyond(input longint v, input logic [23:0] bound);
      longint bd;
      bd = longint'(bound);
      return v >= bd || v <= -bd;
   endfunction

   task automatic predict_polymul(input req_item_type it);
      emit_result_type r;
      int src;
      bit wrap, neg;
      logic [63:0] t1, t2;
      longint s1, s2, off, z, wp;
      case (it.func)
         FUNC_CLEAR: begin
            for (int j = 0; j < NPOS; j++) begin
               acc1_mem[j] = 0;
               acc2_mem[j] = 0;
            end
         end
         FUNC_LOAD: begin
            s1_mem[it.idx] = pack_secret(it.a);
            s2_mem[it.idx] = pack_secret(it.b);
         end
         FUNC_CHAL: begin
            if (it.c == 2'sb01 || it.c == 2'sb11) begin
               for (int j = 0; j < NPOS; j++) begin
                  wrap = j < it.idx;
                  src = wrap ? j + NPOS - it.idx : j - it.idx;
                  neg = wrap ^ (it.c == 2'sb11);
                  t1 = neg ? cfg_negate - s1_mem[src] : s1_mem[src];
                  t2 = neg ? cfg_negate - s2_mem[src] : s2_mem[src];
                  acc1_mem[j] += t1;
                  acc2_mem[j] += t2;
               end
            end
         end
         default: begin
            r.idx = it.idx;
            off = longint'(cfg_offset);
            for (int p = 0; p < 4; p++) begin
               s1 = longint'((acc1_mem[it.idx] >> ((3 - p) * 16)) & 64'hFFFF);
               s2 = longint'((acc2_mem[it.idx] >> ((3 - p) * 16)) & 64'hFFFF);
               z = s1 - off + longint'(signed'(it.a[p]));
               wp = longint'(signed'(it.b[p])) - (s2 - off);
               if (beyond(z, cfg_bound_z) || beyond(wp, cfg_bound_w))
                  reject_seen = 1;
               r.z[p] = z[24:0];
               r.wp[p] = wp[24:0];
            end
            r.rej = reject_seen;
            emit_q.push_back(r);
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         predict_polymul(cur_item);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_gap <= 0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_valid <= 0;
            req_gap <= req_gap - 1;
         end else if (pending_q.size() > 0 && !(!quiet && $urandom_range(0, 9) == 0)) begin
            cur_item = pending_q.pop_front();
            req_valid <= 1;
            req_func <= cur_item.func;
            req_index <= cur_item.idx;
            req_coeff_c <= cur_item.c;
            req_a0 <= cur_item.a[0];
            req_a1 <= cur_item.a[1];
            req_a2 <= cur_item.a[2];
            req_a3 <= cur_item.a[3];
            req_b0 <= cur_item.b[0];
            req_b1 <= cur_item.b[1];
            req_b2 <= cur_item.b[2];
            req_b3 <= cur_item.b[3];
         end else begin
            req_valid <= 0;
            if (pending_q.size() > 0)
               req_gap <= $urandom_range(0, 15);
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 0;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 0;
         rsp_gap <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      emit_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (emit_q.size() == 0) begin
            report("unexpected transfer, index", 64'(rsp_out_index), 0);
         end else begin
            e = emit_q.pop_front();
            if (rsp_out_index !== e.idx) report("out_index", 64'(rsp_out_index), 64'(e.idx));
            if (rsp_z0 !== e.z[0]) report("z0", 64'(rsp_z0), 64'(e.z[0]));
            if (rsp_z1 !== e.z[1]) report("z1", 64'(rsp_z1), 64'(e.z[1]));
            if (rsp_z2 !== e.z[2]) report("z2", 64'(rsp_z2), 64'(e.z[2]));
            if (rsp_z3 !== e.z[3]) report("z3", 64'(rsp_z3), 64'(e.z[3]));
            if (rsp_wp0 !== e.wp[0]) report("wp0", 64'(rsp_wp0), 64'(e.wp[0]));
            if (rsp_wp1 !== e.wp[1]) report("wp1", 64'(rsp_wp1), 64'(e.wp[1]));
            if (rsp_wp2 !== e.wp[2]) report("wp2", 64'(rsp_wp2), 64'(e.wp[2]));
            if (rsp_wp3 !== e.wp[3]) report("wp3", 64'(rsp_wp3), 64'(e.wp[3]));
            if (rsp_rejected !== e.rej) report("rejected", 64'(rsp_rejected), 64'(e.rej));
         end
      end
   end

   // watchdog: cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("tb_packed_sparse_polymul_bound_check_unit: FAIL");
         $finish;
      end
   end

   task automatic csr_write(input csr_type reg_id, input logic [63:0] value);
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= PADDR_W'(8 * int'(reg_id));
      pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      case (reg_id)
         CSR_ETA:     cfg_eta = value[7:0];
         CSR_NEGATE:  cfg_negate = value;
         CSR_OFFSET:  cfg_offset = value[15:0];
         CSR_BOUND_Z: cfg_bound_z = value[23:0];
         default:     cfg_bound_w = value[23:0];
      endcase
   endtask

   task automatic drain;
      while (pending_q.size() > 0 || req_valid || emit_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coef();
      case ($urandom_range(0, 3))
         0: return 24'($urandom_range(0, 40)) - 24'd20;
         1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic add_item(input func_type f, input int idx, input logic signed [1:0] c,
                           input logic [23:0] av, input logic [23:0] bv, input bit rnd);
      req_item_type it;
      it.func = f;
      it.idx = 10'(idx);
      it.c = c;
      for (int p = 0; p < 4; p++) begin
         it.a[p] = rnd ? rand_coef() : av;
         it.b[p] = rnd ? rand_coef() : bv;
      end
      pending_q.push_back(it);
   endtask

   task automatic add_random(input int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            add_item(FUNC_LOAD, $urandom_range(0, NPOS - 1), 2'($urandom), 0, 0, 1);
         else if (r < 52)
            add_item(FUNC_CHAL, $urandom_range(0, NPOS - 1), 2'($urandom), 0, 0, 1);
         else if (r < 97)
            add_item(FUNC_EMIT, $urandom_range(0, NPOS - 1), 2'($urandom), 0, 0, 1);
         else
            add_item(FUNC_CLEAR, $urandom_range(0, NPOS - 1), 2'($urandom), 0, 0, 1);
      end
   endtask

   initial begin
      err_count = 0;
      quiet = 0;
      reject_seen = 0;
      cfg_eta = 8'd2;
      cfg_negate = 0;
      cfg_offset = 0;
      cfg_bound_z = 0;
      cfg_bound_w = 0;
      for (int j = 0; j < NPOS; j++) begin
         acc1_mem[j] = 0;
         acc2_mem[j] = 0;
      end
      reset = 1;
      req_valid = 0;
      req_func = 0;
      req_index = 0;
      req_coeff_c = 0;
      {req_a0, req_a1, req_a2, req_a3, req_b0, req_b1, req_b2, req_b3} = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset settings, every secret written before any challenge
      add_item(FUNC_EMIT, 0, 0, 24'h7FFFFF, 24'h800000, 0);
      for (int j = 0; j < NPOS; j++)
         add_item(FUNC_LOAD, j, 0, 0, 0, 1);
      add_item(FUNC_LOAD, 0, 0, 24'h7FFFFF, 24'h800000, 0);
      add_item(FUNC_LOAD, NPOS - 1, 0, 24'h800000, 24'h7FFFFF, 0);
      add_item(FUNC_LOAD, 5, 0, 24'hFFFFFF, 24'h000000, 0);
      add_item(FUNC_CHAL, 0, 2'sb01, 0, 0, 0);
      add_item(FUNC_EMIT, 0, 0, 0, 0, 0);
      add_item(FUNC_CHAL, NPOS - 1, 2'sb11, 0, 0, 0);
      add_item(FUNC_CHAL, 3, 2'sb00, 0, 0, 0);
      add_item(FUNC_CHAL, 3, 2'sb10, 0, 0, 0);
      add_item(FUNC_EMIT, NPOS - 1, 0, 24'h800000, 24'h7FFFFF, 0);
      add_item(FUNC_EMIT, 3, 0, 24'h7FFFFF, 24'h800000, 0);
      add_item(FUNC_CLEAR, 0, 0, 0, 0, 0);
      add_item(FUNC_EMIT, 3, 0, 0, 0, 0);
      drain();

      // settings sweep, extremes included
      csr_write(CSR_ETA, 0);
      csr_write(CSR_NEGATE, '1);
      csr_write(CSR_OFFSET, 16'hFFFF);
      csr_write(CSR_BOUND_Z, 24'hFFFFFF);
      csr_write(CSR_BOUND_W, 24'hFFFFFF);
      add_random(110);
      drain();

      csr_write(CSR_ETA, 8'hFF);
      csr_write(CSR_NEGATE, {$urandom, $urandom});
      csr_write(CSR_OFFSET, 16'($urandom));
      csr_write(CSR_BOUND_Z, 24'($urandom_range(1000, 70000)));
      csr_write(CSR_BOUND_W, 24'($urandom_range(1000, 70000)));
      add_random(110);
      drain();

      csr_write(CSR_ETA, 8'($urandom));
      csr_write(CSR_NEGATE, 64'h0004_0004_0004_0004);
      csr_write(CSR_OFFSET, 0);
      csr_write(CSR_BOUND_Z, 0);
      csr_write(CSR_BOUND_W, 24'($urandom));
      add_random(110);
      drain();

      csr_write(CSR_ETA, 8'd2);
      csr_write(CSR_NEGATE, 0);
      csr_write(CSR_OFFSET, 16'd2);
      csr_write(CSR_BOUND_Z, 24'($urandom));
      csr_write(CSR_BOUND_W, 24'($urandom));
      add_random(110);
      drain();

      quiet = 1;
      csr_write(CSR_OFFSET, 16'($urandom));
      add_random(110);
      drain();

      if (err_count == 0)
         $display("tb_packed_sparse_polymul_bound_check_unit: PASS");
      else
         $display("tb_packed_sparse_polymul_bound_check_unit: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pspbc_pkg.sv
sv/packed_sparse_polymul_bound_check_unit.sv
dv/tb_packed_sparse_polymul_bound_check_unit.sv
